// ===== rtl/iee_pkg.sv =====
package iee_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_DIV = 3'd4, OP_MOD = 3'd5, OP_LPAR = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_DIV0 = 3'd1, ERR_FEW = 3'd2, ERR_BIG = 3'd3, ERR_OVF = 3'd4
  } err_e;

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  function automatic logic [1:0] level_of(logic [2:0] code);
    case (code)
      OP_ADD, OP_SUB: level_of = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: level_of = 2'd2;
      default: level_of = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] code_of(logic [7:0] ch);
    case (ch)
      8'h2B: code_of = OP_ADD;
      8'h2D: code_of = OP_SUB;
      8'h2A: code_of = OP_MUL;
      8'h2F: code_of = OP_DIV;
      8'h25: code_of = OP_MOD;
      default: code_of = OP_NONE;
    endcase
  endfunction
endpackage

// ===== rtl/iee_in_if.sv =====
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

// ===== rtl/iee_out_if.sv =====
interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         error;
  modport source (output valid, value, error, input ready);
  modport sink (input valid, value, error, output ready);
endinterface

// ===== rtl/iee_ram.sv =====
module iee_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/iee_divider.sv =====
module iee_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iee_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic [31:0]         result_o
);
  import iee_pkg::*;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, mod_q, mod_d, nq_q, nq_d, nr_q, nr_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; mod_d = mod_q; nq_d = nq_q; nr_d = nr_q;
    done_o = 1'b0;
    rem_sh = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, rem_sh} - {1'b0, dvs_q};
    result_o = mod_q ? (nr_q ? -rem_q : rem_q) : (nq_q ? -quo_q : quo_q);
    if (req_i.start) begin
      busy_d = 1'b1; cnt_d = 6'd0; mod_d = req_i.is_mod; rem_d = '0;
      nq_d = req_i.a[31] ^ req_i.b[31]; nr_d = req_i.a[31];
      quo_d = req_i.a[31] ? -req_i.a : req_i.a;
      dvs_d = req_i.b[31] ? -req_i.b : req_i.b;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0; done_o = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0]; quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh; quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    mod_q <= mod_d; nq_q <= nq_d; nr_q <= nr_d;
  end
endmodule

// ===== rtl/infix_expression_evaluator_top.sv =====
// channel | dir | fields
// in_i    | in  | character[7:0], last
// out_o   | out | value[31:0] signed, error[2:0]
// Each stack reduction passes through S_OPRD, S_OPCHK, S_RB, S_RA and S_ALU; each
// / or % also waits in S_DIV on the shared radix-2 divider. Stack reads go through
// a registered RAM port, so each read takes its own sequencer state.
// ready is low while a word is worked on and while a result word is unread.
// Reset clears counts, accumulator and error; the stack RAMs are not cleared.
module infix_expression_evaluator_top (
  input  logic clk_i,
  input  logic rst_ni,
  iee_in_if.sink    in_i,
  iee_out_if.source out_o
);
  import iee_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001, S_DISP = 10'b0000000010, S_OPRD = 10'b0000000100,
    S_OPCHK = 10'b0000001000, S_RB   = 10'b0000010000, S_RA   = 10'b0000100000,
    S_ALU   = 10'b0001000000, S_DIV  = 10'b0010000000, S_FIN  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_CLOSE = 2'd0, MODE_OP = 2'd1, MODE_FLUSH = 2'd2
  } mode_e;

  state_e state_q, state_d;
  logic [CntW-1:0] opc_q, opc_d, vc_q, vc_d;
  logic [31:0] acc_q, acc_d, b_q, b_d, a_q, a_d, res_q, res_d;
  logic in_num_q, in_num_d, last_q, last_d, pend_q, pend_d;
  logic [2:0] err_q, err_d, top_q, top_d, code_q, code_d;
  logic [7:0] ch_q, ch_d;
  mode_e mode_q, mode_d;

  logic op_we, vs_we;
  logic [PtrW-1:0] op_wa, op_ra, vs_wa, vs_ra;
  logic [2:0] op_wd, op_rd;
  logic [31:0] vs_wd, vs_rd;
  div_req_t div_req;
  logic div_done;
  logic [31:0] div_res;
  logic [35:0] acc10;
  logic [63:0] prod;

  iee_ram #(.Width(3), .Depth(StackDepth)) u_op_ram (
    .clk_i, .we_i(op_we), .waddr_i(op_wa), .wdata_i(op_wd), .raddr_i(op_ra), .rdata_o(op_rd));
  iee_ram #(.Width(32), .Depth(StackDepth)) u_vs_ram (
    .clk_i, .we_i(vs_we), .waddr_i(vs_wa), .wdata_i(vs_wd), .raddr_i(vs_ra), .rdata_o(vs_rd));
  iee_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .result_o(div_res));

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.value = res_q;
  assign out_o.error = err_q;
  assign acc10 = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {28'd0, ch_q - 8'h30};
  assign prod  = a_q * b_q;

  always_comb begin
    state_d = state_q; opc_d = opc_q; vc_d = vc_q; acc_d = acc_q; b_d = b_q; a_d = a_q;
    res_d = res_q; in_num_d = in_num_q; last_d = last_q; pend_d = pend_q; err_d = err_q;
    top_d = top_q; code_d = code_q; ch_d = ch_q; mode_d = mode_q;
    op_we = 1'b0; op_wa = opc_q[PtrW-1:0]; op_wd = code_q;
    vs_we = 1'b0; vs_wa = vc_q[PtrW-1:0]; vs_wd = acc_q;
    op_ra = opc_q[PtrW-1:0] - PtrW'(1); vs_ra = vc_q[PtrW-1:0] - PtrW'(1);
    div_req = '{start: 1'b0, is_mod: (top_q == OP_MOD), a: a_q, b: b_q};
    case (state_q)
      S_IDLE: if (in_i.valid) begin
        ch_d = in_i.character; last_d = in_i.last; state_d = S_DISP;
      end
      S_DISP: begin
        state_d = S_FIN;
        if (err_q == ERR_NONE) begin
          if (ch_q inside {[8'h30:8'h39]}) begin
            in_num_d = 1'b1;
            if (!in_num_q) acc_d = {28'd0, ch_q[3:0]};
            else if (acc10 > 36'h7FFFFFFF) err_d = ERR_BIG;
            else acc_d = acc10[31:0];
          end else if (pend_q) begin
            pend_d = 1'b0;
            if (ch_q == 8'h28) begin
              if (opc_q == CntW'(StackDepth)) err_d = ERR_OVF;
              else begin
                op_we = 1'b1; op_wd = OP_LPAR; opc_d = opc_q + CntW'(1);
              end
            end else if (ch_q == 8'h29) begin
              mode_d = MODE_CLOSE; state_d = S_OPRD;
            end else if (code_of(ch_q) != OP_NONE) begin
              code_d = code_of(ch_q); mode_d = MODE_OP; state_d = S_OPRD;
            end
          end else begin
            state_d = S_DISP; pend_d = 1'b1;
            if (in_num_q) begin
              in_num_d = 1'b0; acc_d = '0;
              if (vc_q == CntW'(StackDepth)) begin
                err_d = ERR_OVF; pend_d = 1'b0; state_d = S_FIN;
              end else begin
                vs_we = 1'b1; vc_d = vc_q + CntW'(1);
              end
            end
          end
        end
      end
      S_OPRD: begin
        if (err_q != ERR_NONE || opc_q == '0) begin
          if (mode_q == MODE_OP && err_q == ERR_NONE) begin
            if (opc_q == CntW'(StackDepth)) err_d = ERR_OVF;
            else begin
              op_we = 1'b1; opc_d = opc_q + CntW'(1);
            end
          end
          state_d = S_FIN;
        end else state_d = S_OPCHK;
      end
      S_OPCHK: begin
        top_d = op_rd;
        if (mode_q == MODE_CLOSE && op_rd == OP_LPAR) begin
          opc_d = opc_q - CntW'(1); state_d = S_FIN;
        end else if (mode_q == MODE_OP &&
                     (op_rd == OP_LPAR || level_of(op_rd) < level_of(code_q))) begin
          if (opc_q == CntW'(StackDepth)) err_d = ERR_OVF;
          else begin
            op_we = 1'b1; opc_d = opc_q + CntW'(1);
          end
          state_d = S_FIN;
        end else begin
          opc_d = opc_q - CntW'(1);
          if (op_rd == OP_LPAR) state_d = S_OPRD;
          else if (vc_q < CntW'(2)) begin
            err_d = ERR_FEW; state_d = S_FIN;
          end else begin
            state_d = S_RB;
          end
        end
      end
      S_RB: begin
        b_d = vs_rd; vs_ra = vc_q[PtrW-1:0] - PtrW'(2); state_d = S_RA;
      end
      S_RA: begin
        a_d = vs_rd; vc_d = vc_q - CntW'(2); state_d = S_ALU;
      end
      S_ALU: begin
        case (top_q)
          OP_ADD: res_d = a_q + b_q;
          OP_SUB: res_d = a_q - b_q;
          OP_MUL: res_d = prod[31:0];
          default: res_d = '0;
        endcase
        if (top_q == OP_DIV || top_q == OP_MOD) begin
          if (b_q == '0) begin
            err_d = ERR_DIV0; state_d = S_FIN;
          end else begin
            div_req.start = 1'b1; state_d = S_DIV;
          end
        end else begin
          vs_we = 1'b1; vs_wd = res_d; vc_d = vc_q + CntW'(1); state_d = S_OPRD;
        end
      end
      S_DIV: if (div_done) begin
        vs_we = 1'b1; vs_wd = div_res; vc_d = vc_q + CntW'(1); state_d = S_OPRD;
      end
      S_FIN: begin
        pend_d = 1'b0;
        if (!last_q) state_d = S_IDLE;
        else if (err_q == ERR_NONE && in_num_q) begin
          in_num_d = 1'b0; acc_d = '0;
          if (vc_q == CntW'(StackDepth)) err_d = ERR_OVF;
          else begin
            vs_we = 1'b1; vc_d = vc_q + CntW'(1);
          end
        end else if (err_q == ERR_NONE && opc_q != '0) begin
          mode_d = MODE_FLUSH; state_d = S_OPRD; last_d = 1'b1;
        end else begin
          res_d = '0;
          if (err_q == ERR_NONE && vc_q != '0) begin
            state_d = S_FIN; pend_d = 1'b1;
          end else state_d = S_OUT;
          if (pend_q) begin
            res_d = vs_rd; state_d = S_OUT; pend_d = 1'b0;
          end
        end
      end
      S_OUT: if (out_o.ready) begin
        state_d = S_IDLE; opc_d = '0; vc_d = '0; acc_d = '0; in_num_d = 1'b0; err_d = ERR_NONE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_OPRD && mode_q == MODE_FLUSH && state_d == S_FIN) last_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; opc_q <= '0; vc_q <= '0; acc_q <= '0; in_num_q <= 1'b0;
      err_q <= ERR_NONE; pend_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; opc_q <= opc_d; vc_q <= vc_d; acc_q <= acc_d;
      in_num_q <= in_num_d; err_q <= err_d; pend_q <= pend_d; last_q <= last_d;
    end
  end
  always_ff @(posedge clk_i) begin
    b_q <= b_d; a_q <= a_d; res_q <= res_d; top_q <= top_d; code_q <= code_d;
    ch_q <= ch_d; mode_q <= mode_d;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opc_q <= CntW'(StackDepth) && vc_q <= CntW'(StackDepth)) else $error("count range");
  a_out_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error != ERR_NONE |-> out_o.value == '0) else $error("err value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res_q)) else $error("out hold");
endmodule
